@@ design/uas_pkg.sv @@
// ----------------------------------------------------------------------------
// uas_pkg
// Shared types, constants and helpers of the 3d upwind advection stencil.
// ----------------------------------------------------------------------------
package uas_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int X_W        = 16;
    localparam int SIZE_YZ_W  = 7;
    localparam int CELL_W     = 4 * WORD_BITS;

    // stencil arithmetic widths
    localparam int SUM4_W     = WORD_BITS + 2;
    localparam int SUM8_W     = WORD_BITS + 3;
    localparam int PROD_W     = 2 * WORD_BITS;
    localparam int TERM_W     = PROD_W - FRAC_BITS;
    localparam int GRP_W      = TERM_W + 2;
    localparam int NET_W      = TERM_W + 5;
    localparam int MAG_W      = NET_W - 1;
    localparam int STEP_W     = 32;
    localparam int HI_W       = MAG_W - 32;
    localparam int HIP_W      = HI_W + STEP_W;
    localparam int LOP_W      = 32 + STEP_W;
    localparam int DOWN_SHIFT = FRAC_BITS + 2;
    localparam int HI_SHIFT   = 32 - DOWN_SHIFT;
    localparam int HI_LIMIT_B = 40;
    localparam int QSUM_W     = HI_LIMIT_B + HI_SHIFT + 1;
    localparam int Q_W        = 49;
    localparam int DIFF_W     = Q_W + 2;

    localparam logic [Q_W-1:0] DELTA_CAP = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic signed [DIFF_W-1:0] SAT_HI =
        DIFF_W'((64'sd1 <<< (WORD_BITS - 1)) - 64'sd1);
    localparam logic signed [DIFF_W-1:0] SAT_LO = -SAT_HI - DIFF_W'(1);

    // output queue
    localparam int OQ_DEPTH   = 16;
    localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W   = OQ_PTR_W + 1;

    typedef enum logic [1:0] {
        REG_STEP_RATIO,
        REG_SIZE_X,
        REG_SIZE_Y,
        REG_SIZE_Z
    } cfg_reg_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] vel_z;
        logic signed [WORD_BITS-1:0] vel_y;
        logic signed [WORD_BITS-1:0] vel_x;
        logic signed [WORD_BITS-1:0] quantity;
    } cell_t;

    typedef struct packed {
        logic             last;
        logic [X_W-1:0]   cx;
        logic [5:0]       cy;
        logic [5:0]       cz;
    } meta_t;

    typedef struct packed {
        logic                        last;
        logic [5:0]                  cz;
        logic [5:0]                  cy;
        logic [X_W-1:0]              cx;
        logic signed [WORD_BITS-1:0] next_value;
    } result_t;

    typedef struct packed {
        logic                full;
        logic [OQ_CNT_W-1:0] used;
        logic [OQ_CNT_W-1:0] count;
    } oq_stat_t;

    function automatic logic signed [WORD_BITS-1:0] vel_of(input cell_t c, input axis_t axis);
        logic signed [WORD_BITS-1:0] v;
        case (axis)
            AXIS_X:  v = c.vel_x;
            AXIS_Y:  v = c.vel_y;
            AXIS_Z:  v = c.vel_z;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ design/upwind_advection_stencil_3d.sv @@
// ----------------------------------------------------------------------------
// upwind_advection_stencil_3d
// Streaming first-order upwind advection update over a 3d grid.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one grid cell per beat in raster order (z fastest, then y,
//   then x). Each cell whose arrival completes the 3x3x3 neighborhood of an
//   interior cell yields one beat on m_* with the updated value and its
//   position; tlast marks the final interior cell of the grid.
//   The cfg channel writes step_ratio, size_x, size_y, size_z (index 0..3);
//   write only while no cell is in flight. cfg_ready is always high.
//   Throughput: one cell per clock while s_tready is high. The result of a
//   neighborhood passes through the buffer read, the stencil pipeline and
//   the two scaling multiplies before it appears on m_*.
//   Plane and row buffers are read at accept and written back in the cycle after.
//   A result slot in the output queue is reserved when its cell is taken, so
//   when the receiver stalls, s_tready drops once 16 results are queued or
//   still in the pipeline.
//   Reset clears the position counters, the pipeline and the queue and loads
//   the register defaults; buffer contents are not cleared.
// ----------------------------------------------------------------------------
module upwind_advection_stencil_3d
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // quantity, vel_x, vel_y, vel_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // next_value, cell_x, cell_y, cell_z, 4 pad bits
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int XW  = uas_pkg::X_W;
    localparam int SW  = uas_pkg::SIZE_YZ_W;
    localparam int RW  = uas_pkg::ROW_W;
    localparam int CLW = uas_pkg::COL_W;

    logic [uas_pkg::STEP_W-1:0] step_ratio_reg;
    logic [XW-1:0]              size_x_reg;
    logic [SW-1:0]              size_y_reg, size_z_reg;
    logic [XW-1:0]              pos_x_reg, pos_x_next;
    logic [RW-1:0]              pos_y_reg, pos_y_next;
    logic [CLW-1:0]             pos_z_reg, pos_z_next;

    logic [XW-1:0]   sx;
    logic [SW-1:0]   ey, ez;
    logic [SW-1:0]   y1, z1;
    logic [XW:0]     x1;
    logic            accept, in_grid, res;
    uas_pkg::meta_t  in_meta;

    logic                                 win_valid;
    uas_pkg::meta_t                       win_meta;
    uas_pkg::cell_t [2:0][2:0][2:0]       win;
    logic                                 net_valid;
    uas_pkg::meta_t                       net_meta;
    logic signed [uas_pkg::WORD_BITS-1:0] net_a;
    logic signed [uas_pkg::NET_W-1:0]     net;
    logic                                 upd_valid;
    uas_pkg::result_t                     upd_result;
    uas_pkg::result_t                     out_result;
    logic                                 oq_room;
    uas_pkg::oq_stat_t                    oq_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_ratio_reg <= 32'd6554;
            size_x_reg     <= 16'd64;
            size_y_reg     <= 7'd64;
            size_z_reg     <= 7'd64;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (uas_pkg::cfg_reg_t'(cfg_index))
                uas_pkg::REG_STEP_RATIO: step_ratio_reg <= cfg_data;
                uas_pkg::REG_SIZE_X:     size_x_reg     <= cfg_data[XW-1:0];
                uas_pkg::REG_SIZE_Y:     size_y_reg     <= cfg_data[SW-1:0];
                uas_pkg::REG_SIZE_Z:     size_z_reg     <= cfg_data[SW-1:0];
                default:                 step_ratio_reg <= step_ratio_reg;
            endcase
        end
    end

    // effective sizes: zero acts as one, plane dims capped at the buffer size
    always_comb
    begin
        sx = (size_x_reg == '0) ? XW'(1) : size_x_reg;
        if (size_y_reg == '0)
            ey = SW'(1);
        else if (size_y_reg > SW'(uas_pkg::MAX_ROWS))
            ey = SW'(uas_pkg::MAX_ROWS);
        else
            ey = size_y_reg;
        if (size_z_reg == '0)
            ez = SW'(1);
        else if (size_z_reg > SW'(uas_pkg::MAX_COLS))
            ez = SW'(uas_pkg::MAX_COLS);
        else
            ez = size_z_reg;
    end

    assign accept  = s_tvalid && s_tready;
    assign in_grid = (pos_x_reg < sx) && (SW'(pos_y_reg) < ey) && (SW'(pos_z_reg) < ez);
    assign res     = in_grid && (pos_x_reg >= XW'(2)) && (pos_y_reg >= RW'(2))
                     && (pos_z_reg >= CLW'(2));

    always_comb
    begin
        in_meta.cx   = pos_x_reg - XW'(1);
        in_meta.cy   = 6'(pos_y_reg - RW'(1));
        in_meta.cz   = 6'(pos_z_reg - CLW'(1));
        in_meta.last = (pos_x_reg == sx - XW'(1)) && (SW'(pos_y_reg) == ey - SW'(1))
                       && (SW'(pos_z_reg) == ez - SW'(1));
    end

    always_comb
    begin
        z1 = SW'(pos_z_reg) + SW'(1);
        y1 = SW'(pos_y_reg) + SW'(1);
        x1 = (XW+1)'(pos_x_reg) + (XW+1)'(1);
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        pos_z_next = pos_z_reg;
        if (z1 >= ez)
        begin
            pos_z_next = '0;
            if (y1 >= ey)
            begin
                pos_y_next = '0;
                pos_x_next = (x1 >= (XW+1)'(sx)) ? '0 : x1[XW-1:0];
            end
            else
            begin
                pos_y_next = y1[RW-1:0];
            end
        end
        else
        begin
            pos_z_next = z1[CLW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
        end
        else if (accept)
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            pos_z_reg <= pos_z_next;
        end
    end

    uas_window u_window
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_inside (in_grid),
        .in_res    (res),
        .in_meta   (in_meta),
        .in_cell   (uas_pkg::cell_t'(s_tdata)),
        .in_y      (pos_y_reg),
        .in_z      (pos_z_reg),
        .win_valid (win_valid),
        .win_meta  (win_meta),
        .win       (win)
    );

    uas_flux u_flux
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .win_valid (win_valid),
        .win_meta  (win_meta),
        .win       (win),
        .net_valid (net_valid),
        .net_meta  (net_meta),
        .net_a     (net_a),
        .net       (net)
    );

    uas_update u_update
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_ratio (step_ratio_reg),
        .net_valid  (net_valid),
        .net_meta   (net_meta),
        .net_a      (net_a),
        .net        (net),
        .upd_valid  (upd_valid),
        .upd_result (upd_result)
    );

    uas_outq u_outq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .reserve    (accept && res),
        .push_valid (upd_valid),
        .push_data  (upd_result),
        .pop_valid  (m_tvalid),
        .pop_ready  (m_tready),
        .pop_data   (out_result),
        .room       (oq_room),
        .stat       (oq_stat)
    );

    assign s_tready = oq_room;
    assign m_tdata  = {4'b0000, out_result.cz, out_result.cy, out_result.cx,
                       out_result.next_value};
    assign m_tlast  = out_result.last;

`ifndef ASSERT_OFF
    // a finished result always finds a reserved slot
    assert property (@(posedge clk) disable iff (!rst_n)
        upd_valid |-> !oq_stat.full)
        else $error("result pushed into a full output queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        oq_stat.used <= 5'(uas_pkg::OQ_DEPTH))
        else $error("output queue reservations exceed its depth");

    // queued results are a subset of reserved slots
    assert property (@(posedge clk) disable iff (!rst_n)
        oq_stat.count <= oq_stat.used)
        else $error("more queued results than reservations");
`endif

endmodule

@@ design/uas_window.sv @@
// ----------------------------------------------------------------------------
// uas_window
// Plane and row buffers with read-modify-write, and the 3x3x3 cell window.
// ----------------------------------------------------------------------------
module uas_window
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_inside,
    input  logic                                 in_res,
    input  uas_pkg::meta_t                       in_meta,
    input  uas_pkg::cell_t                       in_cell,
    input  logic [uas_pkg::ROW_W-1:0]            in_y,
    input  logic [uas_pkg::COL_W-1:0]            in_z,
    output logic                                 win_valid,
    output uas_pkg::meta_t                       win_meta,
    output uas_pkg::cell_t [2:0][2:0][2:0]       win
);

    localparam int C        = uas_pkg::CELL_W;
    localparam int PADDR_W  = uas_pkg::ROW_W + uas_pkg::COL_W;
    localparam int PDEPTH   = uas_pkg::MAX_ROWS * uas_pkg::MAX_COLS;

    // plane entry: cell at x-1 in the low half, x-2 in the high half
    logic [2*C-1:0] plane_mem [PDEPTH];
    // row entry: column of row y-1 low, row y-2 high; each column x, x-1, x-2 from low
    logic [6*C-1:0] row_mem [uas_pkg::MAX_COLS];

    logic [2*C-1:0]              pm_rd_reg;
    logic [6*C-1:0]              rb_rd_reg;
    logic                        s1_wr_reg;
    logic                        s1_res_reg;
    uas_pkg::meta_t              s1_meta_reg;
    uas_pkg::cell_t              s1_cell_reg;
    logic [PADDR_W-1:0]          s1_paddr_reg;
    logic [uas_pkg::COL_W-1:0]   s1_z_reg;
    logic                        win_valid_reg;
    uas_pkg::meta_t              win_meta_reg;
    uas_pkg::cell_t [2:0][2:0][2:0] win_reg;

    logic [3*C-1:0]              col_y;
    logic [3*C-1:0]              cols [3];
    uas_pkg::cell_t [2:0][2:0]   slice;

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            pm_rd_reg <= plane_mem[{in_y, in_z}];
            rb_rd_reg <= row_mem[in_z];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_wr_reg     <= 1'b0;
            s1_res_reg    <= 1'b0;
            win_valid_reg <= 1'b0;
        end
        else
        begin
            s1_wr_reg     <= in_valid && in_inside;
            s1_res_reg    <= in_res;
            win_valid_reg <= s1_wr_reg && s1_res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_meta_reg  <= in_meta;
        s1_cell_reg  <= in_cell;
        s1_paddr_reg <= {in_y, in_z};
        s1_z_reg     <= in_z;
        win_meta_reg <= s1_meta_reg;
    end

    always_comb
    begin
        col_y   = {pm_rd_reg[2*C-1:C], pm_rd_reg[C-1:0], s1_cell_reg};
        cols[0] = rb_rd_reg[6*C-1:3*C];
        cols[1] = rb_rd_reg[3*C-1:0];
        cols[2] = col_y;
        for (int dx = 0; dx < 3; dx++)
        begin
            for (int dy = 0; dy < 3; dy++)
            begin
                slice[dx][dy] = cols[dy][(2-dx)*C +: C];
            end
        end
    end

    // write back in the cycle after the read
    always_ff @(posedge clk)
    begin
        if (s1_wr_reg)
        begin
            plane_mem[s1_paddr_reg] <= {pm_rd_reg[C-1:0], s1_cell_reg};
            row_mem[s1_z_reg]       <= {rb_rd_reg[3*C-1:0], col_y};
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_wr_reg)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= slice;
        end
    end

    assign win_valid = win_valid_reg;
    assign win_meta  = win_meta_reg;
    assign win       = win_reg;

endmodule

@@ design/uas_flux.sv @@
// ----------------------------------------------------------------------------
// uas_flux
// Vertex velocities, upwind selection, face products and net flux sum.
// ----------------------------------------------------------------------------
module uas_flux
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   win_valid,
    input  uas_pkg::meta_t                         win_meta,
    input  uas_pkg::cell_t [2:0][2:0][2:0]         win,
    output logic                                   net_valid,
    output uas_pkg::meta_t                         net_meta,
    output logic signed [uas_pkg::WORD_BITS-1:0]   net_a,
    output logic signed [uas_pkg::NET_W-1:0]       net
);

    localparam int WB = uas_pkg::WORD_BITS;

    logic                        v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    uas_pkg::meta_t              m2_reg, m3_reg, m4_reg, m5_reg, m6_reg;
    logic signed [WB-1:0]        qc_reg, a3_reg, a4_reg, a5_reg, a6_reg;
    logic signed [WB-1:0]        qp_reg [3];
    logic signed [WB-1:0]        qm_reg [3];

    logic signed [uas_pkg::SUM4_W-1:0] psum_c   [3][8][2];
    logic signed [uas_pkg::SUM4_W-1:0] psum_reg [3][8][2];
    logic signed [WB-1:0]              v_c      [3][8];
    logic signed [WB-1:0]              up_c     [3][8];
    logic signed [WB-1:0]              v_reg    [3][8];
    logic signed [WB-1:0]              up_reg   [3][8];
    logic signed [uas_pkg::PROD_W-1:0] prod_reg [3][8];
    logic signed [uas_pkg::GRP_W-1:0]  grp_c    [3][2];
    logic signed [uas_pkg::GRP_W-1:0]  grp_reg  [3][2];
    logic signed [uas_pkg::NET_W-1:0]  net_c;
    logic signed [uas_pkg::NET_W-1:0]  net_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= win_valid;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // half sums of the eight cells around each vertex
    always_comb
    begin
        int m, ix, iy, iz;
        for (int d = 0; d < 3; d++)
        begin
            for (int n = 0; n < 8; n++)
            begin
                for (int h = 0; h < 2; h++)
                begin
                    psum_c[d][n][h] = '0;
                    for (int k = 0; k < 4; k++)
                    begin
                        m  = h * 4 + k;
                        ix = ((m & 1) != 0) ? (((n & 1) != 0) ? 2 : 0) : 1;
                        iy = ((m & 2) != 0) ? (((n & 2) != 0) ? 2 : 0) : 1;
                        iz = ((m & 4) != 0) ? (((n & 4) != 0) ? 2 : 0) : 1;
                        psum_c[d][n][h] = psum_c[d][n][h] + uas_pkg::SUM4_W'(
                            uas_pkg::vel_of(win[iz][ix][iy], uas_pkg::axis_t'(d)));
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        psum_reg  <= psum_c;
        qc_reg    <= win[1][1][1].quantity;
        qp_reg[0] <= win[1][2][1].quantity;
        qp_reg[1] <= win[1][1][2].quantity;
        qp_reg[2] <= win[2][1][1].quantity;
        qm_reg[0] <= win[1][0][1].quantity;
        qm_reg[1] <= win[1][1][0].quantity;
        qm_reg[2] <= win[0][1][1].quantity;
        m2_reg    <= win_meta;
    end

    // vertex velocity, floor of sum over 8, then pick the upwind quantity
    always_comb
    begin
        logic signed [uas_pkg::SUM8_W-1:0] s8;
        for (int d = 0; d < 3; d++)
        begin
            for (int n = 0; n < 8; n++)
            begin
                s8 = uas_pkg::SUM8_W'(psum_reg[d][n][0])
                   + uas_pkg::SUM8_W'(psum_reg[d][n][1]);
                v_c[d][n] = s8[uas_pkg::SUM8_W-1:3];
                if (((n >> d) & 1) != 0)
                begin
                    up_c[d][n] = v_c[d][n][WB-1] ? qp_reg[d] : qc_reg;
                end
                else
                begin
                    up_c[d][n] = (!v_c[d][n][WB-1] && (v_c[d][n] != '0)) ? qm_reg[d] : qc_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg  <= v_c;
        up_reg <= up_c;
        a3_reg <= qc_reg;
        m3_reg <= m2_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int d = 0; d < 3; d++)
        begin
            for (int n = 0; n < 8; n++)
            begin
                prod_reg[d][n] <= v_reg[d][n] * up_reg[d][n];
            end
        end
        a4_reg <= a3_reg;
        m4_reg <= m3_reg;
    end

    // floor shift of each product, summed per axis and face side
    always_comb
    begin
        for (int d = 0; d < 3; d++)
        begin
            grp_c[d][0] = '0;
            grp_c[d][1] = '0;
            for (int n = 0; n < 8; n++)
            begin
                grp_c[d][(n >> d) & 1] = grp_c[d][(n >> d) & 1] + uas_pkg::GRP_W'(
                    $signed(prod_reg[d][n][uas_pkg::PROD_W-1:uas_pkg::FRAC_BITS]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg <= grp_c;
        a5_reg  <= a4_reg;
        m5_reg  <= m4_reg;
    end

    always_comb
    begin
        net_c = '0;
        for (int d = 0; d < 3; d++)
        begin
            net_c = net_c + uas_pkg::NET_W'(grp_reg[d][1]) - uas_pkg::NET_W'(grp_reg[d][0]);
        end
    end

    always_ff @(posedge clk)
    begin
        net_reg <= net_c;
        a6_reg  <= a5_reg;
        m6_reg  <= m5_reg;
    end

    assign net_valid = v6_reg;
    assign net_meta  = m6_reg;
    assign net_a     = a6_reg;
    assign net       = net_reg;

endmodule

@@ design/uas_update.sv @@
// ----------------------------------------------------------------------------
// uas_update
// Scales the net flux by the step ratio and applies the saturated update.
// ----------------------------------------------------------------------------
module uas_update
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [uas_pkg::STEP_W-1:0]             step_ratio,
    input  logic                                   net_valid,
    input  uas_pkg::meta_t                         net_meta,
    input  logic signed [uas_pkg::WORD_BITS-1:0]   net_a,
    input  logic signed [uas_pkg::NET_W-1:0]       net,
    output logic                                   upd_valid,
    output uas_pkg::result_t                       upd_result
);

    localparam int WB = uas_pkg::WORD_BITS;

    logic                             v7_reg, v8_reg, v9_reg, v10_reg;
    uas_pkg::meta_t                   m7_reg, m8_reg, m9_reg;
    logic signed [WB-1:0]             a7_reg, a8_reg, a9_reg;
    logic                             neg7_reg, neg8_reg, neg9_reg;
    logic [uas_pkg::MAG_W-1:0]        mag_reg;
    logic [uas_pkg::HIP_W-1:0]        hi_reg;
    logic [uas_pkg::LOP_W-1:0]        lo_reg;
    logic [uas_pkg::Q_W-1:0]          q_reg;
    logic [uas_pkg::Q_W-1:0]          q_next;
    logic [uas_pkg::QSUM_W-1:0]       qsum;
    logic [uas_pkg::NET_W-1:0]        net_neg;
    logic signed [uas_pkg::DIFF_W-1:0] diff;
    logic signed [uas_pkg::DIFF_W-1:0] q_ext;
    logic signed [WB-1:0]             sat_value;
    uas_pkg::result_t                 result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end
        else
        begin
            v7_reg  <= net_valid;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
        end
    end

    assign net_neg = -net;

    always_ff @(posedge clk)
    begin
        neg7_reg <= net[uas_pkg::NET_W-1];
        mag_reg  <= net[uas_pkg::NET_W-1] ? net_neg[uas_pkg::MAG_W-1:0]
                                          : net[uas_pkg::MAG_W-1:0];
        a7_reg   <= net_a;
        m7_reg   <= net_meta;
    end

    // split product of the magnitude and the step ratio
    always_ff @(posedge clk)
    begin
        hi_reg   <= uas_pkg::HIP_W'(mag_reg[uas_pkg::MAG_W-1:32]) * uas_pkg::HIP_W'(step_ratio);
        lo_reg   <= uas_pkg::LOP_W'(mag_reg[31:0]) * uas_pkg::LOP_W'(step_ratio);
        neg8_reg <= neg7_reg;
        a8_reg   <= a7_reg;
        m8_reg   <= m7_reg;
    end

    always_comb
    begin
        qsum = uas_pkg::QSUM_W'({hi_reg[uas_pkg::HI_LIMIT_B-1:0], {uas_pkg::HI_SHIFT{1'b0}}})
             + uas_pkg::QSUM_W'(lo_reg[uas_pkg::LOP_W-1:uas_pkg::DOWN_SHIFT]);
        if ((|hi_reg[uas_pkg::HIP_W-1:uas_pkg::HI_LIMIT_B])
            || (qsum > uas_pkg::QSUM_W'(uas_pkg::DELTA_CAP)))
        begin
            q_next = uas_pkg::DELTA_CAP;
        end
        else
        begin
            q_next = qsum[uas_pkg::Q_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        neg9_reg <= neg8_reg;
        a9_reg   <= a8_reg;
        m9_reg   <= m8_reg;
    end

    // a negative flux adds to the value
    always_comb
    begin
        q_ext = $signed({2'b00, q_reg});
        diff  = neg9_reg ? (uas_pkg::DIFF_W'(a9_reg) + q_ext)
                         : (uas_pkg::DIFF_W'(a9_reg) - q_ext);
        if (diff > uas_pkg::SAT_HI)
        begin
            sat_value = WB'(uas_pkg::SAT_HI);
        end
        else if (diff < uas_pkg::SAT_LO)
        begin
            sat_value = WB'(uas_pkg::SAT_LO);
        end
        else
        begin
            sat_value = diff[WB-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.next_value <= sat_value;
        result_reg.cx         <= m9_reg.cx;
        result_reg.cy         <= m9_reg.cy;
        result_reg.cz         <= m9_reg.cz;
        result_reg.last       <= m9_reg.last;
    end

    assign upd_valid  = v10_reg;
    assign upd_result = result_reg;

endmodule

@@ design/uas_outq.sv @@
// ----------------------------------------------------------------------------
// uas_outq
// Result queue with slot reservation at input accept, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module uas_outq
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 reserve,
    input  logic                 push_valid,
    input  uas_pkg::result_t     push_data,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output uas_pkg::result_t     pop_data,
    output logic                 room,
    output uas_pkg::oq_stat_t    stat
);

    localparam int PW = uas_pkg::OQ_PTR_W;
    localparam int CW = uas_pkg::OQ_CNT_W;

    uas_pkg::result_t  q_mem [uas_pkg::OQ_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     used_reg, used_next;
    logic              pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = count_reg != '0;
    assign pop_data  = q_mem[rd_ptr_reg];
    assign room      = used_reg < CW'(uas_pkg::OQ_DEPTH);

    always_comb
    begin
        count_next = count_reg + CW'(push_valid) - CW'(pop);
        used_next  = used_reg + CW'(reserve) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            used_reg   <= '0;
        end
        else
        begin
            if (push_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

    assign stat.full  = count_reg == CW'(uas_pkg::OQ_DEPTH);
    assign stat.used  = used_reg;
    assign stat.count = count_reg;

endmodule

@@ verif/upwind_advection_stencil_3d_test.sv @@
// ----------------------------------------------------------------------------
// upwind_advection_stencil_3d_test
// Streams whole grids of cells through the stencil and checks every updated
// interior cell against a predictor that keeps its own copy of the planes.
// ----------------------------------------------------------------------------
module upwind_advection_stencil_3d_test;

    localparam int CLK_PERIOD = 12;
    localparam int DRAIN_WAIT = 24;
    localparam int IDLE_LIMIT = 3000;

    typedef struct {
        logic signed [31:0] next_value;
        logic [15:0]        cell_x;
        logic [5:0]         cell_y;
        logic [5:0]         cell_z;
        logic               last_cell;
    } update_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    // predictor state
    int          plane_q [3][64][64][4];
    int unsigned step_ratio;
    int unsigned size_x, size_y, size_z;
    int unsigned pos_x, pos_y, pos_z;
    update_t     pending_updates[$];

    int errors;
    int cells_sent;
    int updates_seen;
    int saturated_seen;
    int idle_cycles;
    int burst_left;
    bit pacing_on;
    int stall_mode;
    int stall_count;

    upwind_advection_stencil_3d uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic longint cell_word(input int px, input int py, input int pz,
                                         input int c);
        return longint'(plane_q[px % 3][py % 64][pz % 64][c]);
    endfunction

    // four times the net flux of the centre cell, Q.16
    function automatic longint flux_sum4(input int cx, input int cy, input int cz);
        longint net;
        longint sum;
        longint vert;
        longint up;
        longint prod;
        int     sg[3];
        int     off[3];
        int     nb[3];
        net = 0;
        for (int d = 0; d < 3; d++)
        begin
            for (int n = 0; n < 8; n++)
            begin
                for (int j = 0; j < 3; j++)
                    sg[j] = ((n >> j) & 1) ? 1 : -1;
                sum = 0;
                for (int m = 0; m < 8; m++)
                begin
                    for (int j = 0; j < 3; j++)
                        off[j] = ((m >> j) & 1) ? sg[j] : 0;
                    sum += cell_word(cx + off[0], cy + off[1], cz + off[2], 1 + d);
                end
                vert = sum >>> 3;
                nb[0] = cx;
                nb[1] = cy;
                nb[2] = cz;
                nb[d] += sg[d];
                up = cell_word(cx, cy, cz, 0);
                if ((sg[d] > 0 && vert < 0) || (sg[d] < 0 && vert > 0))
                    up = cell_word(nb[0], nb[1], nb[2], 0);
                prod = (vert * up) >>> uas_pkg::FRAC_BITS;
                net += (sg[d] > 0) ? prod : -prod;
            end
        end
        return net;
    endfunction

    task automatic predict_cell(input logic [127:0] cell_bits);
        int unsigned sx, ey, ez, x, y, z;
        longint      net, delta, nxt, aval;
        bit [63:0]   mag, hi, lo, q;
        update_t     upd;
        sx = (size_x != 0) ? size_x : 1;
        ey = (size_y == 0) ? 1 : (size_y > uas_pkg::MAX_ROWS) ? uas_pkg::MAX_ROWS : size_y;
        ez = (size_z == 0) ? 1 : (size_z > uas_pkg::MAX_COLS) ? uas_pkg::MAX_COLS : size_z;
        x = pos_x;
        y = pos_y;
        z = pos_z;
        if (x < sx && y < ey && z < ez)
        begin
            for (int c = 0; c < 4; c++)
                plane_q[x % 3][y][z][c] = cell_bits[32*c +: 32];
            if (x >= 2 && y >= 2 && z >= 2)
            begin
                aval = cell_word(x - 1, y - 1, z - 1, 0);
                net = flux_sum4(x - 1, y - 1, z - 1);
                mag = (net < 0) ? -net : net;
                hi = (mag >> 32) * step_ratio;
                lo = (mag & 64'hffff_ffff) * step_ratio;
                if (hi >= (64'd1 << 40))
                    q = 64'd1 << 48;
                else
                    q = (hi << (32 - uas_pkg::DOWN_SHIFT)) + (lo >> uas_pkg::DOWN_SHIFT);
                if (q > (64'd1 << 48))
                    q = 64'd1 << 48;
                delta = (net < 0) ? -longint'(q) : longint'(q);
                nxt = aval - delta;
                if (nxt > 64'sd2147483647 || nxt < -64'sd2147483648)
                    saturated_seen++;
                if (nxt > 64'sd2147483647)
                    nxt = 64'sd2147483647;
                if (nxt < -64'sd2147483648)
                    nxt = -64'sd2147483648;
                upd.next_value = nxt[31:0];
                upd.cell_x = 16'(x - 1);
                upd.cell_y = 6'(y - 1);
                upd.cell_z = 6'(z - 1);
                upd.last_cell = (x == sx - 1 && y == ey - 1 && z == ez - 1);
                pending_updates.push_back(upd);
            end
        end
        if (z + 1 >= ez)
        begin
            pos_z = 0;
            if (y + 1 >= ey)
            begin
                pos_y = 0;
                pos_x = (x + 1 >= sx) ? 0 : ((x + 1) & 16'hffff);
            end
            else
                pos_y = y + 1;
        end
        else
            pos_z = z + 1;
    endtask

    // one beat on the slave side, with bursts and gaps when pacing is on
    task automatic send_cell(input logic [31:0] qty, input logic [31:0] vx,
                             input logic [31:0] vy, input logic [31:0] vz);
        int gap;
        if (pacing_on && burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {vz, vy, vx, qty};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_cell({vz, vy, vx, qty});
        cells_sent++;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            2:       return 32'($urandom_range(0, 32'h3_ffff)) - 32'h2_0000;
            default: return 32'($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
        endcase
    endfunction

    task automatic send_random_cell();
        send_cell(rand_word(), rand_word(), rand_word(), rand_word());
    endtask

    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_updates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input uas_pkg::cfg_reg_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            uas_pkg::REG_STEP_RATIO: step_ratio = value;
            uas_pkg::REG_SIZE_X:     size_x = value[15:0];
            uas_pkg::REG_SIZE_Y:     size_y = value[6:0];
            uas_pkg::REG_SIZE_Z:     size_z = value[6:0];
            default:                 ;
        endcase
    endtask

    task automatic set_grid(input int sx, input int sy, input int sz);
        wait_quiet();
        write_reg(uas_pkg::REG_SIZE_X, sx);
        write_reg(uas_pkg::REG_SIZE_Y, sy);
        write_reg(uas_pkg::REG_SIZE_Z, sz);
    endtask

    task automatic send_grid();
        do
            send_random_cell();
        while (pos_x != 0 || pos_y != 0 || pos_z != 0);
    endtask

    // smallest grid with the reset step ratio, fields at their extremes
    task automatic test_field_extremes();
        logic [31:0] vals[6];
        vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff,
                 32'h0001_0000, 32'hffff_0000};
        set_grid(3, 3, 3);
        for (int i = 0; i < 27; i++)
            send_cell(vals[i % 6], vals[(i + 1) % 6], vals[(i * 5 + 2) % 6],
                      vals[(i * 7 + 3) % 6]);
    endtask

    task automatic test_step_ratio_extremes();
        wait_quiet();
        write_reg(uas_pkg::REG_STEP_RATIO, 32'h0);
        send_grid();
        wait_quiet();
        write_reg(uas_pkg::REG_STEP_RATIO, 32'hffff_ffff);
        send_grid();
        wait_quiet();
        write_reg(uas_pkg::REG_STEP_RATIO, 32'h0001_0000);
    endtask

    task automatic test_plane_shapes();
        // oversized row and column counts act as the maximum
        set_grid(3, 127, 3);
        send_grid();
        set_grid(4, 3, 127);
        send_grid();
        // zero and undersized axes give no interior cells
        set_grid(3, 3, 0);
        send_grid();
        set_grid(0, 3, 3);
        send_grid();
        set_grid(2, 5, 5);
        send_grid();
        set_grid(3, 2, 1);
        send_grid();
    endtask

    // shrink size_x mid-grid so the position lands outside the grid
    task automatic test_position_out_of_range();
        set_grid(65535, 3, 3);
        repeat (40) send_random_cell();
        wait_quiet();
        write_reg(uas_pkg::REG_SIZE_X, 3);
        while (pos_x != 0 || pos_y != 0 || pos_z != 0)
            send_random_cell();
        send_grid();
    endtask

    task automatic test_random_grids();
        int phase;
        phase = 0;
        while (cells_sent < 1900)
        begin
            set_grid($urandom_range(3, 6), $urandom_range(3, 8), $urandom_range(3, 8));
            case ($urandom_range(0, 3))
                0:       write_reg(uas_pkg::REG_STEP_RATIO, $urandom);
                1:       write_reg(uas_pkg::REG_STEP_RATIO, $urandom_range(0, 32'h0002_0000));
                default: write_reg(uas_pkg::REG_STEP_RATIO, $urandom_range(0, 32'h0000_4000));
            endcase
            pacing_on = (phase % 4) != 1;
            send_grid();
            phase++;
        end
        pacing_on = 1'b1;
    endtask

    // receiver stall pattern, re-chosen whenever stall_count wraps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            stall_mode  <= 0;
            stall_count <= 0;
        end
        else
        begin
            if (stall_count == 49)
            begin
                stall_count <= 0;
                stall_mode  <= $urandom_range(0, 3);
            end
            else
                stall_count <= stall_count + 1;
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (stall_count % 16) > 11;
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        update_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            updates_seen++;
            if (pending_updates.size() == 0)
            begin
                $display("unexpected beat on m side: %h", m_tdata);
                errors++;
            end
            else
            begin
                want = pending_updates.pop_front();
                if (m_tdata[31:0] !== want.next_value)
                    report("next_value", $signed(m_tdata[31:0]), want.next_value);
                if (m_tdata[47:32] !== want.cell_x)
                    report("cell_x", m_tdata[47:32], want.cell_x);
                if (m_tdata[53:48] !== want.cell_y)
                    report("cell_y", m_tdata[53:48], want.cell_y);
                if (m_tdata[59:54] !== want.cell_z)
                    report("cell_z", m_tdata[59:54], want.cell_z);
                if (m_tlast !== want.last_cell)
                    report("last_cell", m_tlast, want.last_cell);
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = uas_pkg::REG_STEP_RATIO;
        cfg_data   = '0;
        idle_cycles = 0;
        errors     = 0;
        cells_sent = 0;
        updates_seen = 0;
        saturated_seen = 0;
        burst_left = 0;
        pacing_on  = 1'b1;
        step_ratio = 6554;
        size_x     = 64;
        size_y     = 64;
        size_z     = 64;
        pos_x      = 0;
        pos_y      = 0;
        pos_z      = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_step_ratio_extremes();
        test_plane_shapes();
        test_position_out_of_range();
        test_random_grids();

        wait_quiet();
        $display("sent %0d cells, checked %0d interior updates (%0d saturated)",
                 cells_sent, updates_seen, saturated_seen);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
design/uas_pkg.sv
design/uas_window.sv
design/uas_flux.sv
design/uas_update.sv
design/uas_outq.sv
design/upwind_advection_stencil_3d.sv
verif/upwind_advection_stencil_3d_test.sv
